// ----- rtl/hfdw_pkg.sv -----
package hfdw_pkg;

    localparam int POS_W      = 16;
    localparam int ELEM_W     = 15;
    localparam int FACET_W    = 11;
    localparam int STATUS_W   = 3;
    localparam int SIZE_W     = 5;
    localparam int DOF_W      = 4;
    localparam int SEL_W      = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 5;

    localparam int MAX_ORDER_DEF = 16;
    localparam int MAX_DOF_DEF   = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_X  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_Y  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_Z  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FACET_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FACET_Y = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DOF     = 4'd7;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_PAIR     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INNER    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OUTER    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FACE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd4;

    typedef enum logic [3:0] {
        PH_ACTIVE = 4'b0001,
        PH_INNER  = 4'b0010,
        PH_OUTER  = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] stride;
        logic [POS_W-1:0] stop;
    } bounds_t;

    typedef struct packed {
        bounds_t outer;
        bounds_t inner;
    } loops_t;

    typedef struct packed {
        loops_t           elem;
        loops_t           facet;
        logic             face_ok;
        logic [DOF_W-1:0] dof;
    } walk_cfg_t;

    typedef struct packed {
        logic [ELEM_W-1:0]   elem_index;
        logic [FACET_W-1:0]  facet_index;
        logic                last;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ----- rtl/hex_face_dof_index_walker.sv -----
// The result word of an accepted request is shown the cycle after.
// Throughput: one request per cycle while in_stall is low; the walker steps its position on each accepted request.
// After reset and after every configuration write the request side stalls
// while the two-stage loop bounds registers are refreshed from the configuration.
// Reset: configuration registers take their reset values and the walk is done.
module hex_face_dof_index_walker
    import hfdw_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int MAX_DOF   = MAX_DOF_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ELEM_W-1:0]     elem_index,
    output logic [FACET_W-1:0]    facet_index,
    output logic                  last,
    output logic [STATUS_W-1:0]   status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    walk_cfg_t wcfg;
    logic      settling;
    logic      in_acc;
    result_t   res, out_reg;
    logic      out_valid_reg;

    hfdw_bounds #(
        .MAX_ORDER (MAX_ORDER),
        .MAX_DOF   (MAX_DOF)
    ) u_bounds (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wcfg      (wcfg),
        .settling  (settling)
    );

    hfdw_walker #(
        .MAX_DOF (MAX_DOF)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_acc),
        .restart (restart),
        .wcfg    (wcfg),
        .res     (res)
    );

    // A new word may enter while the output register is being emptied.
    assign in_stall  = settling || (out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign elem_index  = out_reg.elem_index;
    assign facet_index = out_reg.facet_index;
    assign last        = out_reg.last;
    assign status      = out_reg.status;

    a_cfg_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> in_stall)
        else $error("request accepted before loop bounds settled");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid)
        else $error("accepted request produced no result word");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_PAIR) |-> (elem_index == '0) && (facet_index == '0) && !last)
        else $error("non-pair result carries index or last");

endmodule

// ----- rtl/hfdw_bounds.sv -----
module hfdw_bounds
    import hfdw_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int MAX_DOF   = MAX_DOF_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output walk_cfg_t             wcfg,
    output logic                  settling
);

    localparam logic [SEL_W-1:0] FACE_X_LO = 3'd0;
    localparam logic [SEL_W-1:0] FACE_X_HI = 3'd1;
    localparam logic [SEL_W-1:0] FACE_Y_HI = 3'd2;
    localparam logic [SEL_W-1:0] FACE_Y_LO = 3'd3;
    localparam logic [SEL_W-1:0] FACE_Z_LO = 3'd4;
    localparam logic [SEL_W-1:0] FACE_Z_HI = 3'd5;

    localparam logic [SEL_W-1:0] ORI_FWD_UNIT = 3'd0;
    localparam logic [SEL_W-1:0] ORI_UNIT_REV = 3'd1;
    localparam logic [SEL_W-1:0] ORI_REV_DOWN = 3'd2;
    localparam logic [SEL_W-1:0] ORI_DOWN_FWD = 3'd3;
    localparam logic [SEL_W-1:0] ORI_UNIT_FWD = 3'd4;
    localparam logic [SEL_W-1:0] ORI_FWD_DOWN = 3'd5;
    localparam logic [SEL_W-1:0] ORI_DOWN_REV = 3'd6;

    logic [SIZE_W-1:0] ex_reg, ey_reg, ez_reg, fx_reg, fy_reg;
    logic [SEL_W-1:0]  face_reg, orient_reg;
    logic [DOF_W-1:0]  dof_reg;
    logic [1:0]        settle_reg;

    // First stage: clamped sizes and the pairwise products.
    logic [SIZE_W-1:0]   ox_reg, oy_reg, oz_reg, qx_reg, qy_reg;
    logic [2*SIZE_W-1:0] oyz_reg, oxy_reg, qxy_reg;
    logic [DOF_W-1:0]    dofe_reg;

    walk_cfg_t wcfg_reg, wcfg_next;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (32'(v) > MAX_ORDER)
        begin
            r = SIZE_W'(MAX_ORDER);
        end
        return r;
    endfunction

    function automatic bounds_t mk(input logic [POS_W-1:0] s, input logic [POS_W-1:0] st,
                                   input logic [POS_W-1:0] e);
        bounds_t b;
        b.start  = s;
        b.stride = st;
        b.stop   = e;
        return b;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_reg     <= SIZE_W'(1);
            ey_reg     <= SIZE_W'(1);
            ez_reg     <= SIZE_W'(1);
            fx_reg     <= SIZE_W'(1);
            fy_reg     <= SIZE_W'(1);
            face_reg   <= '0;
            orient_reg <= '0;
            dof_reg    <= DOF_W'(1);
            settle_reg <= 2'd2;
        end
        else
        begin
            if (cfg_valid)
            begin
                settle_reg <= 2'd2;
                case (cfg_index)
                    CFG_ELEM_X:  ex_reg     <= cfg_data;
                    CFG_ELEM_Y:  ey_reg     <= cfg_data;
                    CFG_ELEM_Z:  ez_reg     <= cfg_data;
                    CFG_FACET_X: fx_reg     <= cfg_data;
                    CFG_FACET_Y: fy_reg     <= cfg_data;
                    CFG_FACE:    face_reg   <= cfg_data[SEL_W-1:0];
                    CFG_ORIENT:  orient_reg <= cfg_data[SEL_W-1:0];
                    CFG_DOF:     dof_reg    <= cfg_data[DOF_W-1:0];
                    default:     ;
                endcase
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ox_reg  <= clamp_size(ex_reg);
        oy_reg  <= clamp_size(ey_reg);
        oz_reg  <= clamp_size(ez_reg);
        qx_reg  <= clamp_size(fx_reg);
        qy_reg  <= clamp_size(fy_reg);
        oyz_reg <= clamp_size(ey_reg) * clamp_size(ez_reg);
        oxy_reg <= clamp_size(ex_reg) * clamp_size(ey_reg);
        qxy_reg <= clamp_size(fx_reg) * clamp_size(fy_reg);
        if (dof_reg == '0)
        begin
            dofe_reg <= DOF_W'(1);
        end
        else if (32'(dof_reg) > MAX_DOF)
        begin
            dofe_reg <= DOF_W'(MAX_DOF);
        end
        else
        begin
            dofe_reg <= dof_reg;
        end
    end

    // Second stage products, each a single multiply after the first stage.
    logic [POS_W-1:0] n_w, ox1_oyz, oxy1_oz, oy1_oz, qx1_qy;
    logic [POS_W-1:0] oz_w, oyz_w, qy_w, qxy_w;
    bounds_t fwd_b, unit_b, rev_b, down_b, einner_b;

    always_comb
    begin
        n_w     = POS_W'(ox_reg * oyz_reg);
        ox1_oyz = POS_W'((ox_reg - SIZE_W'(1)) * oyz_reg);
        oxy1_oz = POS_W'((oxy_reg - (2*SIZE_W)'(1)) * oz_reg);
        oy1_oz  = POS_W'((oy_reg - SIZE_W'(1)) * oz_reg);
        qx1_qy  = POS_W'((qx_reg - SIZE_W'(1)) * qy_reg);
        oz_w    = POS_W'(oz_reg);
        oyz_w   = POS_W'(oyz_reg);
        qy_w    = POS_W'(qy_reg);
        qxy_w   = POS_W'(qxy_reg);

        fwd_b    = mk('0, qy_w, qxy_w);
        unit_b   = mk('0, POS_W'(1), qy_w);
        rev_b    = mk(qx1_qy, -qy_w, -qy_w);
        down_b   = mk(qy_w - POS_W'(1), '1, '1);
        einner_b = mk('0, POS_W'(1), oz_w);

        wcfg_next         = wcfg_reg;
        wcfg_next.dof     = dofe_reg;
        wcfg_next.face_ok = 1'b1;
        wcfg_next.elem.inner = einner_b;
        case (face_reg)
            FACE_X_LO: wcfg_next.elem.outer = mk('0, oyz_w, n_w);
            FACE_X_HI: wcfg_next.elem.outer = mk(ox1_oyz, oz_w, n_w);
            FACE_Y_HI: wcfg_next.elem.outer = mk(oxy1_oz, -oyz_w, -oz_w);
            FACE_Y_LO: wcfg_next.elem.outer = mk(oy1_oz, -oz_w, -oz_w);
            FACE_Z_LO:
            begin
                wcfg_next.elem.outer = mk('0, oz_w, oyz_w);
                wcfg_next.elem.inner = mk('0, oyz_w, n_w);
            end
            FACE_Z_HI:
            begin
                // The outer end stays at the full point count, unlike the face above.
                wcfg_next.elem.outer = mk(oz_w - POS_W'(1), oyz_w, n_w);
                wcfg_next.elem.inner = mk('0, oz_w, oyz_w);
            end
            default:
            begin
                wcfg_next.face_ok = 1'b0;
            end
        endcase

        case (orient_reg)
            ORI_FWD_UNIT:
            begin
                wcfg_next.facet.outer = fwd_b;
                wcfg_next.facet.inner = unit_b;
            end
            ORI_UNIT_REV:
            begin
                wcfg_next.facet.outer = unit_b;
                wcfg_next.facet.inner = rev_b;
            end
            ORI_REV_DOWN:
            begin
                wcfg_next.facet.outer = rev_b;
                wcfg_next.facet.inner = down_b;
            end
            ORI_DOWN_FWD:
            begin
                wcfg_next.facet.outer = down_b;
                wcfg_next.facet.inner = fwd_b;
            end
            ORI_UNIT_FWD:
            begin
                wcfg_next.facet.outer = unit_b;
                wcfg_next.facet.inner = fwd_b;
            end
            ORI_FWD_DOWN:
            begin
                wcfg_next.facet.outer = fwd_b;
                wcfg_next.facet.inner = down_b;
            end
            ORI_DOWN_REV:
            begin
                wcfg_next.facet.outer = down_b;
                wcfg_next.facet.inner = rev_b;
            end
            default:
            begin
                wcfg_next.facet.outer = rev_b;
                wcfg_next.facet.inner = unit_b;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        wcfg_reg <= wcfg_next;
    end

    assign wcfg     = wcfg_reg;
    assign settling = (settle_reg != 2'd0);

endmodule

// ----- rtl/hfdw_walker.sv -----
module hfdw_walker
    import hfdw_pkg::*;
#(
    parameter int MAX_DOF = MAX_DOF_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic      restart,
    input  walk_cfg_t wcfg,
    output result_t   res
);

    localparam int KW = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;

    phase_t           phase_reg, phase_next, phase_cur;
    logic [POS_W-1:0] ro_reg, ri_reg, fo_reg, fi_reg;
    logic [POS_W-1:0] ro_next, ri_next, fo_next, fi_next;
    logic [POS_W-1:0] ro_cur, ri_cur, fo_cur, fi_cur;
    logic [KW-1:0]    k_reg, k_next, k_cur;

    logic [POS_W-1:0]       rsum, fsum, rj_adv, fj_adv, ro_adv, fo_adv;
    logic [POS_W+DOF_W-1:0] eprod, fprod;
    logic [7:0]             k_inc;
    logic                   wrap, ie, fe, oe, ofe;

    // A restart word loads the loop starts before the step is taken.
    always_comb
    begin
        phase_cur = phase_reg;
        ro_cur    = ro_reg;
        ri_cur    = ri_reg;
        fo_cur    = fo_reg;
        fi_cur    = fi_reg;
        k_cur     = k_reg;
        if (restart)
        begin
            phase_cur = PH_ACTIVE;
            ro_cur    = wcfg.elem.outer.start;
            ri_cur    = wcfg.elem.inner.start;
            fo_cur    = wcfg.facet.outer.start;
            fi_cur    = wcfg.facet.inner.start;
            k_cur     = '0;
        end
    end

    always_comb
    begin
        rsum   = ro_cur + ri_cur;
        fsum   = fo_cur + fi_cur;
        eprod  = {{DOF_W{1'b0}}, rsum} * {{POS_W{1'b0}}, wcfg.dof};
        fprod  = {{DOF_W{1'b0}}, fsum} * {{POS_W{1'b0}}, wcfg.dof};
        k_inc  = 8'(k_cur) + 8'd1;
        wrap   = (k_inc >= {4'd0, wcfg.dof});
        rj_adv = ri_cur + wcfg.elem.inner.stride;
        fj_adv = fi_cur + wcfg.facet.inner.stride;
        ro_adv = ro_cur + wcfg.elem.outer.stride;
        fo_adv = fo_cur + wcfg.facet.outer.stride;
        ie     = (rj_adv == wcfg.elem.inner.stop);
        fe     = (fj_adv == wcfg.facet.inner.stop);
        oe     = (ro_adv == wcfg.elem.outer.stop);
        ofe    = (fo_adv == wcfg.facet.outer.stop);

        phase_next = phase_cur;
        ro_next    = ro_cur;
        ri_next    = ri_cur;
        fo_next    = fo_cur;
        fi_next    = fi_cur;
        k_next     = k_cur;
        res        = '0;
        res.status = ST_DONE;

        case (phase_cur)
            PH_ACTIVE:
            begin
                if (!wcfg.face_ok)
                begin
                    res.status = ST_BAD_FACE;
                    phase_next = PH_DONE;
                end
                else
                begin
                    res.status      = ST_PAIR;
                    res.elem_index  = ELEM_W'(eprod + (POS_W+DOF_W)'(k_cur));
                    res.facet_index = FACET_W'(fprod + (POS_W+DOF_W)'(k_cur));
                    k_next          = wrap ? '0 : k_inc[KW-1:0];
                    if (wrap)
                    begin
                        ri_next = rj_adv;
                        fi_next = fj_adv;
                        if (ie || fe)
                        begin
                            if (!(ie && fe))
                            begin
                                phase_next = PH_INNER;
                            end
                            else
                            begin
                                ro_next = ro_adv;
                                fo_next = fo_adv;
                                if (oe || ofe)
                                begin
                                    phase_next = (oe && ofe) ? PH_DONE : PH_OUTER;
                                end
                                else
                                begin
                                    ri_next = wcfg.elem.inner.start;
                                    fi_next = wcfg.facet.inner.start;
                                end
                            end
                        end
                    end
                    res.last = (phase_next != PH_ACTIVE);
                end
            end
            PH_INNER:
            begin
                res.status = ST_INNER;
                phase_next = PH_DONE;
            end
            PH_OUTER:
            begin
                res.status = ST_OUTER;
                phase_next = PH_DONE;
            end
            default:
            begin
                res.status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            ro_reg    <= '0;
            ri_reg    <= '0;
            fo_reg    <= '0;
            fi_reg    <= '0;
            k_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            ro_reg    <= ro_next;
            ri_reg    <= ri_next;
            fo_reg    <= fo_next;
            fi_reg    <= fi_next;
            k_reg     <= k_next;
        end
    end

endmodule
